>>> rtl/core/utf8lct_pkg.sv
// Shared types and constants for the UTF-8 line/column tracker.
// No dependencies; imported by every module of the tracker.
`timescale 1ns / 1ps

package utf8lct_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int OUT_WIDTH       = 32;
	localparam int CP_WIDTH        = 21;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] LF_BYTE    = 8'h0A;

	localparam logic [CP_WIDTH-1:0] CP_LF = 21'h0000A;
	localparam logic [CP_WIDTH-1:0] CP_CR = 21'h0000D;
	localparam logic [CP_WIDTH-1:0] CP_LS = 21'h02028;
	localparam logic [CP_WIDTH-1:0] CP_PS = 21'h02029;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_COLUMN,
		EV_LINE
	} ev_t;

	typedef struct packed {
		ev_t  event_kind;
		logic pending;
		logic report;
	} cmd_t;

endpackage

>>> rtl/core/utf8lct_if.sv
// Valid/ready channel interfaces for the tracker's byte input and position output.
// No dependencies.
`timescale 1ns / 1ps

interface utf8lct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       consume;
	logic       report;

	modport source (output valid, output text_byte, output consume, output report,
		input ready);
	modport sink (input valid, input text_byte, input consume, input report,
		output ready);
endinterface

interface utf8lct_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] line_number;
	logic [31:0] column_number;

	modport source (output valid, output line_number, output column_number,
		input ready);
	modport sink (input valid, input line_number, input column_number,
		output ready);
endinterface

>>> rtl/core/utf8_line_column_tracker.sv
// UTF-8 line/column tracker: takes one text byte per cycle while the input
// is ready and reports the line and code point column, both from 1, on
// request. A report transfer passes through the command queue to the output
// register, which returns its position, and restarts the count at line 1,
// column 1. One byte is accepted every cycle in steady state; the rate is set
// by the counter update in the back part. While a report waits for the output
// register to be taken, the two-entry queue takes one more byte and then holds
// the input until the result transfer completes. Counters are COUNT_WIDTH bits
// wide and saturate; reported values saturate at 32 bits.
// Depends on utf8lct_pkg, utf8lct_if, utf8lct_front, utf8lct_queue, utf8lct_back.
`timescale 1ns / 1ps

module utf8_line_column_tracker #(
	parameter int COUNT_WIDTH = utf8lct_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	utf8lct_in_if.sink    in_ch,
	utf8lct_out_if.source out_ch
);
	import utf8lct_pkg::*;

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	utf8lct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (full),
		.push   (push),
		.cmd    (front_cmd)
	);

	utf8lct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (back_cmd),
		.not_empty (not_empty)
	);

	utf8lct_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_cmd   (back_cmd),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

>>> rtl/core/utf8lct_queue.sv
// Short command queue between the decode front and the counter back.
// Depends on utf8lct_pkg.
`timescale 1ns / 1ps

module utf8lct_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utf8lct_pkg::cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output utf8lct_pkg::cmd_t  pop_cmd,
	output logic               not_empty
);
	import utf8lct_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/utf8lct_front.sv
// Decode front: accepts bytes, tracks UTF-8 sequence state and CR/LF pairing,
// and classifies each transfer into a counter command. Depends on utf8lct_pkg, utf8lct_if.
`timescale 1ns / 1ps

module utf8lct_front (
	input  logic               clk,
	input  logic               arst_n,
	utf8lct_in_if.sink         in_ch,
	input  logic               full,
	output logic               push,
	output utf8lct_pkg::cmd_t  cmd
);
	import utf8lct_pkg::*;

	logic [1:0]          bytes_left_q;
	logic [CP_WIDTH-1:0] cp_q;
	logic                after_cr_q;

	logic [1:0]          bytes_left_d;
	logic [CP_WIDTH-1:0] cp_d;
	logic                after_cr_d;
	logic [CP_WIDTH-1:0] done_cp;
	logic                done;
	logic [7:0]          b;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;
	assign b           = in_ch.text_byte;

	always_comb begin
		bytes_left_d = bytes_left_q;
		cp_d         = cp_q;
		after_cr_d   = after_cr_q;
		done         = 1'b0;
		done_cp      = {13'b0, b};
		if (in_ch.consume) begin
			if (bytes_left_q != 2'd0) begin
				cp_d         = {cp_q[CP_WIDTH-7:0], b[5:0] & CONT_MASK[5:0]};
				bytes_left_d = bytes_left_q - 2'd1;
				done_cp      = cp_d;
				done         = (bytes_left_d == 2'd0);
			end else if (after_cr_q && b == LF_BYTE) begin
				after_cr_d = 1'b0;
			end else if (b >= 8'hC0 && b <= 8'hDF) begin
				cp_d         = {13'b0, b & LEAD2_MASK};
				bytes_left_d = 2'd1;
				after_cr_d   = 1'b0;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				cp_d         = {13'b0, b & LEAD3_MASK};
				bytes_left_d = 2'd2;
				after_cr_d   = 1'b0;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				cp_d         = {13'b0, b & LEAD4_MASK};
				bytes_left_d = 2'd3;
				after_cr_d   = 1'b0;
			end else begin
				done = 1'b1;
			end
		end

		cmd.event_kind = EV_NONE;
		if (done) begin
			after_cr_d = (done_cp == CP_CR);
			if (done_cp == CP_LF || done_cp == CP_CR || done_cp == CP_LS
				|| done_cp == CP_PS) begin
				cmd.event_kind = EV_LINE;
			end else begin
				cmd.event_kind = EV_COLUMN;
			end
		end
		cmd.pending = (bytes_left_d != 2'd0);
		cmd.report  = in_ch.report;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			cp_q         <= '0;
			after_cr_q   <= 1'b0;
		end else if (push) begin
			if (in_ch.report) begin
				bytes_left_q <= 2'd0;
				cp_q         <= '0;
				after_cr_q   <= 1'b0;
			end else begin
				bytes_left_q <= bytes_left_d;
				cp_q         <= cp_d;
				after_cr_q   <= after_cr_d;
			end
		end
	end

endmodule

>>> rtl/core/utf8lct_back.sv
// Counter back: applies queued commands to the saturating line and column
// counters and registers reported positions. Depends on utf8lct_pkg, utf8lct_if.
`timescale 1ns / 1ps

module utf8lct_back #(
	parameter int COUNT_WIDTH = utf8lct_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  utf8lct_pkg::cmd_t  q_cmd,
	output logic               pop,
	utf8lct_out_if.source      out_ch
);
	import utf8lct_pkg::*;

	logic [COUNT_WIDTH-1:0] line_q;
	logic [COUNT_WIDTH-1:0] col_q;
	logic [COUNT_WIDTH-1:0] line_d;
	logic [COUNT_WIDTH-1:0] col_d;
	logic [COUNT_WIDTH-1:0] rep_col;
	logic                   out_valid_q;
	logic [OUT_WIDTH-1:0]   line_out_q;
	logic [OUT_WIDTH-1:0]   col_out_q;
	logic                   out_free;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH-1:0] upper;
		upper = v >> OUT_WIDTH;
		return (upper != '0) ? '1 : OUT_WIDTH'(v);
	endfunction

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = q_valid && (!q_cmd.report || out_free);

	always_comb begin
		line_d = line_q;
		col_d  = col_q;
		case (q_cmd.event_kind)
			EV_LINE: begin
				line_d = sat_inc(line_q);
				col_d  = COUNT_WIDTH'(1);
			end
			EV_COLUMN: begin
				col_d = sat_inc(col_q);
			end
			default: begin
				col_d = col_q;
			end
		endcase
		rep_col = q_cmd.pending ? sat_inc(col_d) : col_d;
	end

	always_ff @(posedge clk) begin
		if (pop && q_cmd.report) begin
			line_out_q <= clamp_out(line_d);
			col_out_q  <= clamp_out(rep_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= COUNT_WIDTH'(1);
			col_q       <= COUNT_WIDTH'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_cmd.report) begin
					line_q <= COUNT_WIDTH'(1);
					col_q  <= COUNT_WIDTH'(1);
				end else begin
					line_q <= line_d;
					col_q  <= col_d;
				end
			end
			if (pop && q_cmd.report) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.line_number   = line_out_q;
	assign out_ch.column_number = col_out_q;

endmodule
